// ===== rtl/bhft_pkg.sv =====
// Shared constants, types and arithmetic helpers of the bone palette block.
`default_nettype none
package bhft_pkg;
    localparam int MAX_BONES = 64;
    localparam int FRAC_BITS = 16;
    localparam int BONE_W = $clog2(MAX_BONES);
    localparam int MAT_AW = BONE_W + 4;
    localparam int MAT_DEPTH = MAX_BONES * 16;

    localparam logic [1:0] FUNC_PARENT = 2'd0;
    localparam logic [1:0] FUNC_OFFSET = 2'd1;
    localparam logic [1:0] FUNC_LOCAL = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PRD  = 6'b000010,
        ST_ROOT = 6'b000100,
        ST_FRD  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    // Requests from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic mac;
        logic done;
    } mac_ctl_t;

    // Arithmetic right shift of a 64-bit sum, saturated to 32 bits.
    function automatic logic signed [31:0] fix_norm(input logic [63:0] acc);
        logic signed [63:0] sh;
        sh = $signed(acc) >>> FRAC_BITS;
        if (sh > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (sh < -64'sh8000_0000)
            return 32'sh8000_0000;
        else
            return sh[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/bhft_ram.sv =====
// Generic single-port write, single-port registered-read RAM.
`default_nettype none
module bhft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/bhft_mac.sv =====
// Four-lane multiply-accumulate unit: one 32x32 product per lane per cycle.
`default_nettype none
module bhft_mac (
    input  wire logic                    clk,
    input  wire bhft_pkg::mac_ctl_t      ctl,
    input  wire logic signed [31:0]      a,
    input  wire logic signed [31:0]      b [4],
    output logic signed [31:0]           res [4]
);
    logic signed [63:0] prod_reg [4];
    logic [63:0]        acc_reg [4];
    logic               mac_reg;
    logic               clr_reg;
    logic               done_reg;
    logic               done2_reg;

    // The last product reaches the accumulator in the cycle after done_reg,
    // so the normalized result is taken on done2_reg instead.
    always_ff @(posedge clk)
    begin
        mac_reg   <= ctl.mac;
        clr_reg   <= ctl.clear;
        done_reg  <= ctl.done;
        done2_reg <= done_reg;
        for (int i = 0; i < 4; i++)
        begin
            prod_reg[i] <= a * b[i];
            if (clr_reg)
                acc_reg[i] <= mac_reg ? prod_reg[i] : 64'd0;
            else if (mac_reg)
                acc_reg[i] <= acc_reg[i] + prod_reg[i];
            if (done2_reg)
                res[i] <= bhft_pkg::fix_norm(acc_reg[i]);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/bone_hierarchy_final_transforms.sv =====
// Top level: bone palette forward kinematics over RAM-held matrices.
// An accepted local row 0..2, parent or offset item leaves the block idle; these go back to back.
// A local row 3 of bone 1 and up runs the root product (ST_PRD), writes the root rows
// (ST_ROOT), runs the final product (ST_FRD) and then sends the result rows (ST_OUT);
// the next item is accepted only after the last row is taken, so an output stall holds input.
// Bone 0 skips the root product and writes its local matrix as its root.
// Reset (rst_n, async) clears control and sets bone_count to 1; RAMs are not cleared.
`default_nettype none
module bone_hierarchy_final_transforms (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [6:0]         cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         func,
    input  wire logic [5:0]         bone,
    input  wire logic [1:0]         row,
    input  wire logic [5:0]         parent,
    input  wire logic signed [31:0] elem_a,
    input  wire logic signed [31:0] elem_b,
    input  wire logic signed [31:0] elem_c,
    input  wire logic signed [31:0] elem_d,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [5:0]              out_bone,
    output logic [1:0]              out_row,
    output logic signed [31:0]      res_a,
    output logic signed [31:0]      res_b,
    output logic signed [31:0]      res_c,
    output logic signed [31:0]      res_d,
    output logic                    last
);
    localparam int AW = bhft_pkg::MAT_AW;
    localparam int BW = bhft_pkg::BONE_W;

    bhft_pkg::state_t state_reg, state_next;
    logic [6:0]         bone_count_reg;
    logic [BW-1:0]      bone_reg;
    logic [1:0]         r_reg;
    logic [2:0]         k_reg;
    logic [3:0]         wait_reg;
    logic [1:0]         orow_reg;
    logic signed [31:0] loc_reg [16];
    logic signed [31:0] cur_reg [16];
    logic signed [31:0] fin_reg [16];
    logic               ovalid_reg;

    logic               accept;
    logic               in_range;
    logic [5:0]         par_rd;
    logic [BW-1:0]      par_ra;

    // Matrix RAMs hold a whole 4x4 row per word of 128 bits.
    logic               off_we, root_we;
    logic [AW-3:0]      off_wa, root_wa, off_ra, root_ra;
    logic [127:0]       off_wd, root_wd, off_rd, root_rd;

    bhft_pkg::mac_ctl_t ctl;
    logic signed [31:0] mac_a;
    logic signed [31:0] mac_b [4];
    logic signed [31:0] mac_res [4];

    assign in_range = ({1'b0, bone} < bone_count_reg);
    assign in_ready = state_reg == bhft_pkg::ST_IDLE;
    assign accept   = in_valid && in_ready;

    // The parent entry is read with the incoming bone while idle and held
    // on the bone register afterward, so it stays valid through the root product.
    assign par_ra = in_ready ? bone[BW-1:0] : bone_reg;

    bhft_ram #(.WIDTH(6), .DEPTH(bhft_pkg::MAX_BONES)) u_par (
        .clk(clk), .we(accept && in_range && func == bhft_pkg::FUNC_PARENT),
        .waddr(bone[BW-1:0]), .wdata(parent), .raddr(par_ra), .rdata(par_rd)
    );
    bhft_ram #(.WIDTH(128), .DEPTH(bhft_pkg::MAX_BONES * 4)) u_off (
        .clk(clk), .we(off_we), .waddr(off_wa), .wdata(off_wd),
        .raddr(off_ra), .rdata(off_rd)
    );
    bhft_ram #(.WIDTH(128), .DEPTH(bhft_pkg::MAX_BONES * 4)) u_root (
        .clk(clk), .we(root_we), .waddr(root_wa), .wdata(root_wd),
        .raddr(root_ra), .rdata(root_rd)
    );
    bhft_mac u_mac (.clk(clk), .ctl(ctl), .a(mac_a), .b(mac_b), .res(mac_res));

    assign off_we = accept && in_range && func == bhft_pkg::FUNC_OFFSET;
    assign off_wa = {bone[BW-1:0], row};
    assign off_wd = {elem_d, elem_c, elem_b, elem_a};
    // Root rows: parent rows during the root product, own rows during the final one.
    always_comb
    begin
        root_ra = {(state_reg == bhft_pkg::ST_PRD) ? par_rd[BW-1:0] : bone_reg, k_reg[1:0]};
        off_ra  = {bone_reg, r_reg};
    end

    // Sequence: per output row r, step k feeds a[r][k] and row k of b.
    logic feed;
    logic [1:0] k_col;
    logic [31:0] b_row [4];
    assign feed = (state_reg == bhft_pkg::ST_PRD || state_reg == bhft_pkg::ST_FRD)
                  && k_reg != 3'd0 && k_reg <= 3'd4;
    assign k_col = 2'(k_reg - 3'd1);
    always_comb
    begin
        for (int j = 0; j < 4; j++)
            b_row[j] = root_rd[32*j +: 32];
        ctl.clear = feed && k_reg == 3'd1;
        ctl.mac   = feed;
        ctl.done  = feed && k_reg == 3'd4;
        if (state_reg == bhft_pkg::ST_PRD)
            mac_a = loc_reg[{r_reg, k_col}];
        else
            mac_a = off_rd[32*k_col +: 32];
        for (int j = 0; j < 4; j++)
            mac_b[j] = b_row[j];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bhft_pkg::ST_IDLE:
                if (accept && in_range && func == bhft_pkg::FUNC_LOCAL && row == 2'd3)
                    state_next = (bone == 6'd0) ? bhft_pkg::ST_ROOT : bhft_pkg::ST_PRD;
            bhft_pkg::ST_PRD:
                if (r_reg == 2'd3 && wait_reg == 4'd15)
                    state_next = bhft_pkg::ST_ROOT;
            bhft_pkg::ST_ROOT:
                if (r_reg == 2'd3)
                    state_next = bhft_pkg::ST_FRD;
            bhft_pkg::ST_FRD:
                if (r_reg == 2'd3 && wait_reg == 4'd15)
                    state_next = bhft_pkg::ST_OUT;
            bhft_pkg::ST_OUT:
                if (ovalid_reg && out_ready && orow_reg == 2'd3)
                    state_next = bhft_pkg::ST_IDLE;
            default:
                state_next = bhft_pkg::ST_IDLE;
        endcase
    end

    // Root row write: in ST_ROOT rows come from cur_reg (product or local copy).
    assign root_we = state_reg == bhft_pkg::ST_ROOT;
    assign root_wa = {bone_reg, r_reg};
    assign root_wd = {cur_reg[{r_reg, 2'd3}], cur_reg[{r_reg, 2'd2}],
                      cur_reg[{r_reg, 2'd1}], cur_reg[{r_reg, 2'd0}]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bhft_pkg::ST_IDLE;
            bone_count_reg <= 7'd1;
            ovalid_reg     <= 1'b0;
            r_reg          <= 2'd0;
            k_reg          <= 3'd0;
            wait_reg       <= 4'd0;
            orow_reg       <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                bone_count_reg <= cfg_wdata;
            case (state_reg)
                bhft_pkg::ST_IDLE:
                begin
                    r_reg <= 2'd0; k_reg <= 3'd0; wait_reg <= 4'd0;
                end
                bhft_pkg::ST_PRD, bhft_pkg::ST_FRD:
                begin
                    // Each row: k 0..4 issues reads and MACs, then drain to 15.
                    if (k_reg <= 3'd4)
                        k_reg <= k_reg + 3'd1;
                    wait_reg <= wait_reg + 4'd1;
                    if (wait_reg == 4'd15)
                    begin
                        r_reg <= r_reg + 2'd1; k_reg <= 3'd0; wait_reg <= 4'd0;
                    end
                end
                bhft_pkg::ST_ROOT:
                begin
                    r_reg <= r_reg + 2'd1;
                    k_reg <= 3'd0;
                end
                bhft_pkg::ST_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    if (ovalid_reg && out_ready)
                    begin
                        orow_reg <= orow_reg + 2'd1;
                        if (orow_reg == 2'd3)
                            ovalid_reg <= 1'b0;
                    end
                end
                default:
                    r_reg <= 2'd0;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept && in_range && func == bhft_pkg::FUNC_LOCAL)
        begin
            loc_reg[{row, 2'd0}] <= elem_a;
            loc_reg[{row, 2'd1}] <= elem_b;
            loc_reg[{row, 2'd2}] <= elem_c;
            loc_reg[{row, 2'd3}] <= elem_d;
            bone_reg <= bone[BW-1:0];
            if (row == 2'd3)
            begin
                cur_reg[12] <= elem_a; cur_reg[13] <= elem_b;
                cur_reg[14] <= elem_c; cur_reg[15] <= elem_d;
                for (int i = 0; i < 12; i++)
                    cur_reg[i] <= loc_reg[i];
            end
        end
        if (wait_reg == 4'd12)
            for (int j = 0; j < 4; j++)
            begin
                if (state_reg == bhft_pkg::ST_PRD)
                    cur_reg[{r_reg, 2'(j)}] <= mac_res[j];
                if (state_reg == bhft_pkg::ST_FRD)
                    fin_reg[{r_reg, 2'(j)}] <= mac_res[j];
            end
    end

    assign out_valid = ovalid_reg;
    assign out_bone  = 6'(bone_reg);
    assign out_row   = orow_reg;
    assign res_a     = fin_reg[{orow_reg, 2'd0}];
    assign res_b     = fin_reg[{orow_reg, 2'd1}];
    assign res_c     = fin_reg[{orow_reg, 2'd2}];
    assign res_d     = fin_reg[{orow_reg, 2'd3}];
    assign last      = orow_reg == 2'd3;

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while results pending");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> !out_valid) else $error("beat after last");
    a_root_idle: assert property (@(posedge clk) disable iff (!rst_n)
        root_we |-> !in_ready) else $error("root write while idle");
endmodule
`default_nettype wire
